### src/rsi_pkg.sv
// shared types, register indexes and fixed-point helpers for the ray/sphere intersector
package rsi_pkg;

   localparam int QW = 32;       // width of every fixed-point quantity
   localparam int QUO_W = 33;    // quotient bits produced by a divider
   localparam int DEN_W = 31;    // divisor width (2a saturated, or radius)
   localparam int CSR_IDX_W = 3;
   localparam int WIDE_W = 2 * QW + 2;

   typedef logic signed [QW-1:0] q_type;
   typedef logic [2:0][QW-1:0] q3_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam wide_type Q_MAX_W = 66'sh0_7FFF_FFFF;
   localparam wide_type Q_MIN_W = -66'sh0_8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_CENTER_Z,
      CSR_RADIUS,
      CSR_MIN_DIST
   } csr_index_type;

   typedef struct packed {
      q3_type center;
      logic [DEN_W-1:0] radius;
      logic [DEN_W-1:0] min_dist;
   } cfg_type;

   // item handed from the classifying front to the solving back
   typedef struct packed {
      q3_type o;
      q3_type d;
      q3_type v;
      q_type a;
      q_type b;
      q_type disc;
      logic miss;
   } mid_item_type;

   // side data travelling down the back pipeline
   typedef struct packed {
      q3_type o;
      q3_type d;
      q3_type v;
      logic miss;
      logic neg1;
      logic neg2;
      q_type t;
      logic hit;
      q3_type p;
      logic [2:0] nneg;
   } side_type;

   function automatic q_type sat_q(input wide_type x);
      if (x > Q_MAX_W) begin
         return q_type'(Q_MAX_W);
      end else if (x < Q_MIN_W) begin
         return q_type'(Q_MIN_W);
      end
      return q_type'(x);
   endfunction

   function automatic q_type add_q(input q_type x, input q_type y);
      wide_type s;
      s = wide_type'(x) + wide_type'(y);
      return sat_q(s);
   endfunction

   function automatic q_type sub_q(input q_type x, input q_type y);
      wide_type s;
      s = wide_type'(x) - wide_type'(y);
      return sat_q(s);
   endfunction

   function automatic q_type sum3_q(input q_type x, input q_type y, input q_type z);
      wide_type s;
      s = wide_type'(x) + wide_type'(y) + wide_type'(z);
      return sat_q(s);
   endfunction

   // product rounded towards minus infinity, then saturated
   function automatic q_type qmul_q(input q_type x, input q_type y, input int frac);
      logic signed [2*QW-1:0] prod;
      prod = x * y;
      return sat_q(wide_type'(prod >>> frac));
   endfunction

   // magnitude quotient plus sign back to a saturated signed value
   function automatic q_type div_fix_q(input logic [QUO_W-1:0] q, input logic ovf,
                                       input logic neg);
      if (neg) begin
         if (ovf || q > 33'h0_8000_0000) begin
            return q_type'(Q_MIN_W);
         end
         return -q[QW-1:0];
      end
      if (ovf || q > 33'h0_7FFF_FFFF) begin
         return q_type'(Q_MAX_W);
      end
      return q[QW-1:0];
   endfunction

endpackage

### src/rsi_fifo.sv
// small register-based queue between the front and back halves
module rsi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   cnt_ff;

   assign full  = cnt_ff == (PTR_W + 1)'(DEPTH);
   assign empty = cnt_ff == '0;
   assign dout  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10: cnt_ff <= cnt_ff + 1'b1;
            2'b01: cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end
endmodule

### src/rsi_sqrt.sv
// pipelined integer square root, one root bit per stage
module rsi_sqrt #(
   parameter int IN_W = 47
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [IN_W-1:0]       in_val,
   output logic [(IN_W+1)/2-1:0] out_root
);
   localparam int RT_W  = (IN_W + 1) / 2;
   localparam int PAD_W = 2 * RT_W;
   localparam int REM_W = RT_W + 3;

   logic [REM_W-1:0] rem_ff  [RT_W];
   logic [RT_W-1:0]  root_ff [RT_W];
   logic [PAD_W-1:0] val_ff  [RT_W];

   for (genvar k = 0; k < RT_W; k++) begin : g_stage
      localparam int I = RT_W - 1 - k;
      logic [REM_W-1:0] rem_prev;
      logic [RT_W-1:0]  root_prev;
      logic [PAD_W-1:0] val_prev;
      logic [REM_W-1:0] cur;
      logic [REM_W-1:0] trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign val_prev  = PAD_W'(in_val);
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign val_prev  = val_ff[k-1];
      end

      // bring down the next pair of bits and try root*4+1
      assign cur   = {rem_prev[REM_W-3:0], val_prev[2*I+1 -: 2]};
      assign trial = REM_W'({root_prev, 2'b01});
      assign ge    = cur >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? cur - trial : cur;
            root_ff[k] <= {root_prev[RT_W-2:0], ge};
            val_ff[k]  <= val_prev;
         end
      end
   end

   assign out_root = root_ff[RT_W-1];
endmodule

### src/rsi_div.sv
// pipelined restoring divider on magnitudes, one quotient bit per stage
module rsi_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 31,
   parameter int QUO_W = 33
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic             ovf
);
   localparam int HI_W  = NUM_W - QUO_W;
   localparam int R_W   = DEN_W + 1;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic [R_W-1:0]   r_ff   [QUO_W];
   logic [QUO_W-1:0] q_ff   [QUO_W];
   logic [QUO_W-1:0] lo_ff  [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic             ovf_ff [QUO_W];

   logic [HI_W-1:0] hi;
   logic            ovf_pre;

   // quotient would not fit in QUO_W bits
   assign hi      = num[NUM_W-1:QUO_W];
   assign ovf_pre = CMP_W'(hi) >= CMP_W'(den);

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [R_W-1:0]   r_prev;
      logic [QUO_W-1:0] q_prev;
      logic [QUO_W-1:0] lo_prev;
      logic [DEN_W-1:0] den_prev;
      logic             ovf_prev;
      logic [R_W-1:0]   cur;
      logic             ge;

      if (k == 0) begin : g_first
         assign r_prev   = R_W'(hi);
         assign q_prev   = '0;
         assign lo_prev  = num[QUO_W-1:0];
         assign den_prev = den;
         assign ovf_prev = ovf_pre;
      end else begin : g_next
         assign r_prev   = r_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign lo_prev  = lo_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign ovf_prev = ovf_ff[k-1];
      end

      assign cur = {r_prev[R_W-2:0], lo_prev[QUO_W-1-k]};
      assign ge  = cur >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]   <= ge ? cur - {1'b0, den_prev} : cur;
            q_ff[k]   <= {q_prev[QUO_W-2:0], ge};
            lo_ff[k]  <= lo_prev;
            den_ff[k] <= den_prev;
            ovf_ff[k] <= ovf_prev;
         end
      end
   end

   assign quo = q_ff[QUO_W-1];
   assign ovf = ovf_ff[QUO_W-1];
endmodule

### src/rsi_front.sv
// front half: takes rays, forms the quadratic and classifies miss by discriminant or zero direction
module rsi_front import rsi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_push,
   input  q3_type       in_origin,
   input  q3_type       in_dir,
   input  cfg_type      cfg,
   output logic         in_full,
   input  logic         out_full,
   output logic         out_push,
   output mid_item_type out_item
);
   localparam int STAGES = 6;

   typedef struct packed {
      q3_type o;
      q3_type d;
      q3_type v;
   } ray_type;

   logic [STAGES-1:0] vld_ff;
   logic              en;

   ray_type ray1_ff, ray2_ff, ray3_ff, ray4_ff, ray5_ff;
   ray_type ray1_in;
   q3_type  dd2_ff, vd2_ff, vv2_ff;
   q_type   rr2_ff, rr3_ff;
   q_type   a3_ff, bs3_ff, ss3_ff;
   q_type   a4_ff, b4_ff, cc4_ff;
   q_type   a5_ff, b5_ff, bb5_ff, acq5_ff;
   q_type   rad_q;
   wide_type disc_wide;
   q_type   disc_q;
   mid_item_type out_ff;

   // whole pipe stalls only when its last item cannot enter the queue
   assign en       = !(vld_ff[STAGES-1] && out_full);
   assign in_full  = !en;
   assign out_push = vld_ff[STAGES-1] && !out_full;
   assign out_item = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_push};
      end
   end

   always_comb begin
      ray1_in.o = in_origin;
      ray1_in.d = in_dir;
      for (int i = 0; i < 3; i++) begin
         ray1_in.v[i] = sub_q(in_origin[i], cfg.center[i]);
      end
   end

   assign rad_q     = q_type'({1'b0, cfg.radius});
   assign disc_wide = wide_type'(bb5_ff) - (wide_type'(acq5_ff) <<< 2);
   assign disc_q    = sat_q(disc_wide);

   always_ff @(posedge clock) begin
      if (en) begin
         ray1_ff <= ray1_in;

         ray2_ff <= ray1_ff;
         for (int i = 0; i < 3; i++) begin
            dd2_ff[i] <= qmul_q(ray1_ff.d[i], ray1_ff.d[i], FRAC_BITS);
            vd2_ff[i] <= qmul_q(ray1_ff.v[i], ray1_ff.d[i], FRAC_BITS);
            vv2_ff[i] <= qmul_q(ray1_ff.v[i], ray1_ff.v[i], FRAC_BITS);
         end
         rr2_ff <= qmul_q(rad_q, rad_q, FRAC_BITS);

         ray3_ff <= ray2_ff;
         a3_ff   <= sum3_q(dd2_ff[0], dd2_ff[1], dd2_ff[2]);
         bs3_ff  <= sum3_q(vd2_ff[0], vd2_ff[1], vd2_ff[2]);
         ss3_ff  <= sum3_q(vv2_ff[0], vv2_ff[1], vv2_ff[2]);
         rr3_ff  <= rr2_ff;

         ray4_ff <= ray3_ff;
         a4_ff   <= a3_ff;
         b4_ff   <= add_q(bs3_ff, bs3_ff);
         cc4_ff  <= sub_q(ss3_ff, rr3_ff);

         ray5_ff <= ray4_ff;
         a5_ff   <= a4_ff;
         b5_ff   <= b4_ff;
         bb5_ff  <= qmul_q(b4_ff, b4_ff, FRAC_BITS);
         acq5_ff <= qmul_q(a4_ff, cc4_ff, FRAC_BITS);

         out_ff.o    <= ray5_ff.o;
         out_ff.d    <= ray5_ff.d;
         out_ff.v    <= ray5_ff.v;
         out_ff.a    <= a5_ff;
         out_ff.b    <= b5_ff;
         out_ff.disc <= disc_q;
         // negative discriminant or zero direction
         out_ff.miss <= disc_q[QW-1] || (a5_ff == '0);
      end
   end
endmodule

### src/rsi_back.sv
// back half: root, division for t, hit point and normal
module rsi_back import rsi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_empty,
   input  mid_item_type in_item,
   output logic         in_pop,
   input  cfg_type      cfg,
   output logic         out_empty,
   input  logic         out_pop,
   output logic         out_hit,
   output q_type        out_t,
   output q3_type       out_normal,
   output q3_type       out_point
);
   localparam int SQ_IN_W = DEN_W + FRAC_BITS;
   localparam int SQ_W    = (SQ_IN_W + 1) / 2;
   localparam int NUM_W   = QW + FRAC_BITS;
   localparam int LAT     = SQ_W + 2 * QUO_W + 6;

   logic [LAT-1:0] vld_ff;
   logic           en;

   mid_item_type s0_ff;
   mid_item_type sq_dly_ff [SQ_W];
   logic [SQ_IN_W-1:0] sqrt_in;
   logic [SQ_W-1:0]    root;

   mid_item_type s1_cur;
   logic signed [QW+1:0] nb, er, num1, num2, abs1, abs2;
   side_type        sd1_in, sd1_ff;
   logic [QW-1:0]   n1_ff, n2_ff;
   logic [DEN_W-1:0] den_ff;

   side_type        dv_dly_ff [QUO_W];
   logic [QUO_W-1:0] q1, q2;
   logic            ovf1, ovf2;

   side_type sd2_in, sd2_ff, sd3_ff, sd4_in, sd4_ff;
   side_type s2_cur;
   q_type    t1, t2, mind;
   logic     take1;
   q3_type   dt3_ff;
   q3_type   n4;
   logic [2:0][QW-1:0] nm_in, nm_ff;

   side_type nd_dly_ff [QUO_W];
   logic [2:0][QUO_W-1:0] nq;
   logic [2:0]            novf;
   side_type s5_cur;

   logic   hit_ff;
   q_type  t_ff;
   q3_type nrm_ff, pt_ff;

   // pipe moves whenever the output register is free or being taken
   assign en        = !vld_ff[LAT-1] || out_pop;
   assign in_pop    = en && !in_empty;
   assign out_empty = !vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], !in_empty};
      end
   end

   // stage 0 and the square root of disc shifted up by FRAC_BITS bits
   assign sqrt_in = s0_ff.miss ? '0 : {s0_ff.disc[DEN_W-1:0], {FRAC_BITS{1'b0}}};

   rsi_sqrt #(.IN_W(SQ_IN_W)) u_sqrt (
      .clock    (clock),
      .en       (en),
      .in_val   (sqrt_in),
      .out_root (root)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff        <= in_item;
         sq_dly_ff[0] <= s0_ff;
         for (int k = 1; k < SQ_W; k++) begin
            sq_dly_ff[k] <= sq_dly_ff[k-1];
         end
      end
   end

   // numerators -b -/+ e, exact
   always_comb begin
      s1_cur = sq_dly_ff[SQ_W-1];
      nb     = -((QW + 2)'(s1_cur.b));
      er     = $signed((QW + 2)'(root));
      num1   = nb - er;
      num2   = nb + er;
      abs1   = num1[QW+1] ? -num1 : num1;
      abs2   = num2[QW+1] ? -num2 : num2;
      sd1_in      = '0;
      sd1_in.o    = s1_cur.o;
      sd1_in.d    = s1_cur.d;
      sd1_in.v    = s1_cur.v;
      sd1_in.miss = s1_cur.miss;
      sd1_in.neg1 = num1[QW+1];
      sd1_in.neg2 = num2[QW+1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd1_ff <= sd1_in;
         n1_ff  <= abs1[QW-1:0];
         n2_ff  <= abs2[QW-1:0];
         // a is never negative, so 2a saturates to 31 bits
         den_ff <= s1_cur.a[DEN_W-1] ? '1 : {s1_cur.a[DEN_W-2:0], 1'b0};
      end
   end

   rsi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_near (
      .clock (clock),
      .en    (en),
      .num   ({n1_ff, {FRAC_BITS{1'b0}}}),
      .den   (den_ff),
      .quo   (q1),
      .ovf   (ovf1)
   );

   rsi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_far (
      .clock (clock),
      .en    (en),
      .num   ({n2_ff, {FRAC_BITS{1'b0}}}),
      .den   (den_ff),
      .quo   (q2),
      .ovf   (ovf2)
   );

   // nearer root if beyond min distance, else the farther one
   always_comb begin
      s2_cur = dv_dly_ff[QUO_W-1];
      t1     = div_fix_q(q1, ovf1, s2_cur.neg1);
      t2     = div_fix_q(q2, ovf2, s2_cur.neg2);
      mind   = q_type'({1'b0, cfg.min_dist});
      take1  = t1 > mind;
      sd2_in     = s2_cur;
      sd2_in.t   = take1 ? t1 : t2;
      sd2_in.hit = !s2_cur.miss && (take1 || (t2 > mind));
   end

   always_comb begin
      sd4_in = sd3_ff;
      for (int i = 0; i < 3; i++) begin
         n4[i]          = add_q(sd3_ff.v[i], dt3_ff[i]);
         sd4_in.p[i]    = add_q(sd3_ff.o[i], dt3_ff[i]);
         sd4_in.nneg[i] = n4[i][QW-1];
         nm_in[i]       = n4[i][QW-1] ? (~n4[i] + 1'b1) : n4[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_dly_ff[0] <= sd1_ff;
         for (int k = 1; k < QUO_W; k++) begin
            dv_dly_ff[k] <= dv_dly_ff[k-1];
         end
         sd2_ff <= sd2_in;
         sd3_ff <= sd2_ff;
         for (int i = 0; i < 3; i++) begin
            dt3_ff[i] <= qmul_q(sd2_ff.d[i], sd2_ff.t, FRAC_BITS);
         end
         sd4_ff <= sd4_in;
         nm_ff  <= nm_in;
         nd_dly_ff[0] <= sd4_ff;
         for (int k = 1; k < QUO_W; k++) begin
            nd_dly_ff[k] <= nd_dly_ff[k-1];
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_norm
      rsi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_norm (
         .clock (clock),
         .en    (en),
         .num   ({nm_ff[i], {FRAC_BITS{1'b0}}}),
         .den   (cfg.radius),
         .quo   (nq[i]),
         .ovf   (novf[i])
      );
   end

   assign s5_cur = nd_dly_ff[QUO_W-1];

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= s5_cur.hit;
         t_ff   <= s5_cur.hit ? s5_cur.t : '0;
         for (int i = 0; i < 3; i++) begin
            pt_ff[i]  <= s5_cur.hit ? s5_cur.p[i] : '0;
            // zero radius gives a zero normal
            nrm_ff[i] <= (s5_cur.hit && cfg.radius != '0) ?
                         div_fix_q(nq[i], novf[i], s5_cur.nneg[i]) : '0;
         end
      end
   end

   assign out_hit    = hit_ff;
   assign out_t      = t_ff;
   assign out_normal = nrm_ff;
   assign out_point  = pt_ff;
endmodule

### src/ray_sphere_intersect.sv
// Ray/sphere intersector, Q(32-FRAC_BITS).FRAC_BITS fixed point, one result per ray.
// Takes one ray per clock and gives one result per clock when the result side keeps
// popping. A ray passes the front pipeline (quadratic and discriminant), then a
// MID_DEPTH-entry queue, then the back pipeline, whose length is set by the
// square root, one root bit per stage, and the two divider chains, one quotient bit
// per stage. Sphere registers are read live, so write them only with no ray in flight.
module ray_sphere_intersect import rsi_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int MID_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic signed [QW-1:0] req_origin_x,
   input  logic signed [QW-1:0] req_origin_y,
   input  logic signed [QW-1:0] req_origin_z,
   input  logic signed [QW-1:0] req_dir_x,
   input  logic signed [QW-1:0] req_dir_y,
   input  logic signed [QW-1:0] req_dir_z,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic                 rsp_hit,
   output logic signed [QW-1:0] rsp_t_hit,
   output logic signed [QW-1:0] rsp_normal_x,
   output logic signed [QW-1:0] rsp_normal_y,
   output logic signed [QW-1:0] rsp_normal_z,
   output logic signed [QW-1:0] rsp_point_x,
   output logic signed [QW-1:0] rsp_point_y,
   output logic signed [QW-1:0] rsp_point_z,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [QW-1:0]        csr_wdata
);
   localparam int MID_W = $bits(mid_item_type);

   cfg_type      cfg_ff;
   q3_type       origin, dir;
   logic         mid_push, mid_full, mid_pop, mid_empty;
   mid_item_type front_item;
   logic [MID_W-1:0] mid_dout;
   q_type        t_out;
   q3_type       nrm_out, pt_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center   <= '0;
         cfg_ff.radius   <= DEN_W'(65536);
         cfg_ff.min_dist <= DEN_W'(66);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_X: cfg_ff.center[0] <= csr_wdata;
            CSR_CENTER_Y: cfg_ff.center[1] <= csr_wdata;
            CSR_CENTER_Z: cfg_ff.center[2] <= csr_wdata;
            CSR_RADIUS:   cfg_ff.radius    <= csr_wdata[DEN_W-1:0];
            CSR_MIN_DIST: cfg_ff.min_dist  <= csr_wdata[DEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign origin = {req_origin_z, req_origin_y, req_origin_x};
   assign dir    = {req_dir_z, req_dir_y, req_dir_x};

   rsi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_push   (req_push),
      .in_origin (origin),
      .in_dir    (dir),
      .cfg       (cfg_ff),
      .in_full   (req_full),
      .out_full  (mid_full),
      .out_push  (mid_push),
      .out_item  (front_item)
   );

   rsi_fifo #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .din   (front_item),
      .full  (mid_full),
      .pop   (mid_pop),
      .dout  (mid_dout),
      .empty (mid_empty)
   );

   rsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_empty   (mid_empty),
      .in_item    (mid_item_type'(mid_dout)),
      .in_pop     (mid_pop),
      .cfg        (cfg_ff),
      .out_empty  (rsp_empty),
      .out_pop    (rsp_pop),
      .out_hit    (rsp_hit),
      .out_t      (t_out),
      .out_normal (nrm_out),
      .out_point  (pt_out)
   );

   assign rsp_t_hit    = t_out;
   assign rsp_normal_x = nrm_out[0];
   assign rsp_normal_y = nrm_out[1];
   assign rsp_normal_z = nrm_out[2];
   assign rsp_point_x  = pt_out[0];
   assign rsp_point_y  = pt_out[1];
   assign rsp_point_z  = pt_out[2];

`ifndef SYNTHESIS
   a_mid_no_overflow: assert property (@(posedge clock) disable iff (reset)
      mid_push |-> !mid_full) else $error("item pushed into full mid queue");
   a_full_from_queue: assert property (@(posedge clock) disable iff (reset)
      req_full |-> mid_full) else $error("front stalled with room in mid queue");
   a_miss_zero_t: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_hit) |-> (rsp_t_hit == '0 && rsp_point_x == '0))
      else $error("miss item carries nonzero fields");
   a_hit_beyond_min: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_hit) |-> (rsp_t_hit > $signed({1'b0, cfg_ff.min_dist})))
      else $error("hit item not beyond min distance");
`endif
endmodule
